// ===== rtl/kf2_pkg.sv =====
// ============================================================================
// kf2_pkg: shared types and constants for the two-state Kalman filter core
// Payload structs, request codes, configuration indices and the sequencer
// states used by the core and its shared multiply/accumulate datapath.
// ============================================================================
package kf2_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DW             = DATA_WIDTH_DEF;
  localparam int NUM_CFG        = 8;
  localparam int CFG_IDX_W      = 3;

  localparam logic [1:0] REQ_PREDICT = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_LOAD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_F00 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_F01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_F10 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_F11 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Q00 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Q11 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_R   = 3'd7;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [DW-1:0] measurement;
    logic signed [DW-1:0] init_angle;
    logic signed [DW-1:0] init_velocity;
    logic signed [DW-1:0] init_p00;
    logic signed [DW-1:0] init_p01;
    logic signed [DW-1:0] init_p10;
    logic signed [DW-1:0] init_p11;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] angle_est;
    logic signed [DW-1:0] velocity_est;
    logic                 gain_skipped;
    logic                 saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_DIVWAIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/kf2_div.sv =====
// ============================================================================
// kf2_div: radix-2 restoring divider for the filter gains
// Computes round-to-nearest (ties away) of (n * 2^FRAC) / d, one quotient
// bit per cycle, and returns the signed result clamped to DATA_WIDTH bits.
// ============================================================================
module kf2_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quo,
  output logic                         sat
);
  localparam int NW = DATA_WIDTH + FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);
  localparam int DWD = DATA_WIDTH + 1;

  logic [NW-1:0]  dvd_r, dvd_nxt;
  logic [DWD:0]   rem_r, rem_nxt;
  logic [DWD-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           neg_r, neg_nxt;
  logic [DWD:0]   shl;
  logic [DWD:0]   diff;
  logic [DWD-1:0] an, ad;
  logic [NW:0]    mag;
  logic signed [NW+1:0] sq;
  logic signed [NW+1:0] smax, smin;

  assign an = num[DATA_WIDTH-1] ? DWD'(-{num[DATA_WIDTH-1], num})
                                : DWD'({num[DATA_WIDTH-1], num});
  assign ad = den[DATA_WIDTH-1] ? DWD'(-{den[DATA_WIDTH-1], den})
                                : DWD'({den[DATA_WIDTH-1], den});
  assign shl  = {rem_r[DWD-1:0], dvd_r[NW-1]};
  assign diff = shl - {1'b0, dsr_r};

  // Shift in one numerator bit per cycle; the numerator carries
  // the half-divisor offset for rounding via a pre-added term.
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    if (start) begin
      dvd_nxt  = NW'({an, {FRAC_BITS{1'b0}}}) + NW'(ad >> 1);
      rem_nxt  = '0;
      dsr_nxt  = ad;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
      neg_nxt  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
    end else if (busy_r) begin
      if (!diff[DWD]) begin
        rem_nxt = diff;
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  // Apply sign and clamp to the word range.
  assign mag  = {1'b0, dvd_r};
  assign sq   = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign smax = (NW+2)'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  assign smin = -smax - 1;
  // Quotient holds once the last bit has been shifted in.
  assign done = ~busy_r;
  assign quo  = (sq > smax) ? DATA_WIDTH'(smax)
              : (sq < smin) ? DATA_WIDTH'(smin) : DATA_WIDTH'(sq);
  assign sat  = (sq > smax) || (sq < smin);
endmodule

// ===== rtl/kalman_filter_2state_velocity_meas_core.sv =====
// ============================================================================
// kalman_filter_2state_velocity_meas_core: two-state Q16.16 Kalman filter
// Load and no-op requests go straight to the result; predict runs the
// MAC micro-program, and update also runs the two gain divides.
// Throughput: one transaction at a time; the shared multiplier does one
// product per cycle and the divider one quotient bit per cycle.
// Reset: state and covariance clear to zero, F=I, Q=0, R=1.0.
// ============================================================================
module kalman_filter_2state_velocity_meas_core #(
  parameter int DATA_WIDTH = kf2_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kf2_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kf2_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [kf2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_wdata
);
  import kf2_pkg::*;

  localparam int PW = 2 * DATA_WIDTH + 2;
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - 1;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS-1));
  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(64'sd1 <<< FRAC_BITS);
  localparam int SW = 5;

  typedef logic signed [DATA_WIDTH-1:0] w_t;

  // Working register file: 0..7 cfg, 8..13 state, 14..21 temps.
  w_t cfg_r [NUM_CFG];
  w_t x0_r, x1_r, p00_r, p01_r, p10_r, p11_r;
  w_t t0_r, t1_r, t2_r, t3_r, y_r, s_r, k0_r, k1_r;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] step_r, step_nxt;
  state_t state_r, state_nxt;
  logic [1:0] req_r;
  w_t meas_r;
  logic sat_r, skip_r, div_sel_r;
  w_t opa, opb;
  logic [2:0] op_add;
  logic [3:0] dst;
  logic last;
  logic signed [PW-1:0] prod, rnd, accv, clv;
  logic clsat;
  w_t clw;
  logic div_start;
  w_t div_q;
  logic div_sat, div_done;
  logic [kf2_pkg::CFG_IDX_W:0] unused_idx;

  function automatic logic signed [PW-1:0] sx(input w_t v);
    return PW'(v);
  endfunction

  // Clamp the accumulated sum of this step to word range.
  always_comb begin
    clsat = (accv > SMAX) || (accv < SMIN);
    clv   = (accv > SMAX) ? SMAX : (accv < SMIN) ? SMIN : accv;
    clw   = DATA_WIDTH'(clv);
  end

  // Micro-program: each step multiplies opa*opb into acc (op_add: 0 mac,
  // 1 add plain opa, 2 sub opa), dst!=0 writes clamped acc and clears it.
  always_comb begin
    opa = '0; opb = '0; op_add = 3'd0; dst = 4'd0; last = 1'b0;
    if (req_r == REQ_PREDICT) begin
      case (step_r)
        // new angle parks in y_r until the old angle is no longer needed
        5'd0:  begin opa = cfg_r[0]; opb = x0_r; end
        5'd1:  begin opa = cfg_r[1]; opb = x1_r; dst = 4'd11; end
        5'd2:  begin opa = cfg_r[2]; opb = x0_r; end
        5'd3:  begin opa = cfg_r[3]; opb = x1_r; dst = 4'd2; end
        5'd4:  begin opa = p00_r; opb = cfg_r[0]; end
        5'd5:  begin opa = p01_r; opb = cfg_r[1]; dst = 4'd7; end
        5'd6:  begin opa = p00_r; opb = cfg_r[2]; end
        5'd7:  begin opa = p01_r; opb = cfg_r[3]; dst = 4'd8; end
        5'd8:  begin opa = p10_r; opb = cfg_r[0]; end
        5'd9:  begin opa = p11_r; opb = cfg_r[1]; dst = 4'd9; end
        5'd10: begin opa = p10_r; opb = cfg_r[2]; end
        5'd11: begin opa = p11_r; opb = cfg_r[3]; dst = 4'd10; end
        5'd12: begin opa = cfg_r[0]; opb = t0_r; end
        5'd13: begin opa = cfg_r[1]; opb = t2_r; end
        5'd14: begin opa = cfg_r[4]; op_add = 3'd1; dst = 4'd3; end
        5'd15: begin opa = cfg_r[0]; opb = t1_r; end
        5'd16: begin opa = cfg_r[1]; opb = t3_r; end
        5'd17: begin opa = cfg_r[5]; op_add = 3'd1; dst = 4'd4; end
        5'd18: begin opa = cfg_r[2]; opb = t0_r; end
        5'd19: begin opa = cfg_r[3]; opb = t2_r; end
        5'd20: begin opa = cfg_r[5]; op_add = 3'd1; dst = 4'd5; end
        5'd21: begin opa = cfg_r[2]; opb = t1_r; end
        5'd22: begin opa = cfg_r[3]; opb = t3_r; end
        5'd23: begin opa = cfg_r[6]; op_add = 3'd1; dst = 4'd6; end
        5'd24: begin opa = y_r; op_add = 3'd1; dst = 4'd1; last = 1'b1; end
        default: ;
      endcase
    end else begin
      case (step_r)
        5'd0:  begin opa = meas_r; op_add = 3'd1; end
        5'd1:  begin opa = x1_r; op_add = 3'd2; dst = 4'd11; end
        5'd2:  begin opa = p11_r; op_add = 3'd1; end
        5'd3:  begin opa = cfg_r[7]; op_add = 3'd1; dst = 4'd12; end
        // steps 4,5 are divides handled by ST_DIV
        5'd6:  begin opa = x0_r; op_add = 3'd1; end
        5'd7:  begin opa = k0_r; opb = y_r; dst = 4'd1; end
        5'd8:  begin opa = x1_r; op_add = 3'd1; end
        5'd9:  begin opa = k1_r; opb = y_r; dst = 4'd2; end
        5'd10: begin opa = k0_r; op_add = 3'd2; dst = 4'd7; end
        5'd11: begin opa = ONE; op_add = 3'd1; end
        5'd12: begin opa = k1_r; op_add = 3'd2; dst = 4'd8; end
        5'd13: begin opa = p00_r; op_add = 3'd1; end
        5'd14: begin opa = t0_r; opb = p10_r; dst = 4'd9; end
        5'd15: begin opa = p01_r; op_add = 3'd1; end
        5'd16: begin opa = t0_r; opb = p11_r; dst = 4'd10; end
        5'd17: begin opa = t1_r; opb = p10_r; dst = 4'd5; end
        5'd18: begin opa = t1_r; opb = p11_r; dst = 4'd6; end
        5'd19: begin opa = t2_r; op_add = 3'd1; dst = 4'd3; end
        5'd20: begin opa = t3_r; op_add = 3'd1; dst = 4'd4; last = 1'b1; end
        default: ;
      endcase
    end
  end

  // Shared multiplier with rounding, and accumulate.
  always_comb begin
    prod = sx(opa) * sx(opb);
    rnd  = (prod + HALF) >>> FRAC_BITS;
    case (op_add)
      3'd1:    accv = acc_r + sx(opa);
      3'd2:    accv = acc_r - sx(opa);
      default: accv = acc_r + rnd;
    endcase
  end

  assign div_start = (state_r == ST_DIV);
  kf2_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_sel_r ? p11_r : p01_r), .den(s_r),
    .done(div_done), .quo(div_q), .sat(div_sat)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_nxt  = '0;
          step_nxt = '0;
          if (in_data.req_type == REQ_PREDICT || in_data.req_type == REQ_UPDATE)
            state_nxt = ST_MAC;
          else
            state_nxt = ST_DONE;
        end
      end
      ST_MAC: begin
        acc_nxt  = (dst != 4'd0) ? '0 : accv;
        step_nxt = step_r + 1'b1;
        if (last) state_nxt = ST_DONE;
        else if (req_r == REQ_UPDATE && step_r == 5'd3) state_nxt = ST_DIV;
      end
      ST_DIV: state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_done) begin
          if (div_sel_r) begin
            state_nxt = ST_MAC;
            step_nxt  = 5'd6;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_data  = '{angle_est: x0_r, velocity_est: x1_r,
                       gain_skipped: skip_r, saturated: sat_r};
  assign unused_idx = {1'b0, cfg_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      acc_r     <= '0;
      sat_r     <= 1'b0;
      skip_r    <= 1'b0;
      div_sel_r <= 1'b0;
      x0_r <= '0; x1_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
      cfg_r[0] <= ONE; cfg_r[1] <= '0; cfg_r[2] <= '0; cfg_r[3] <= ONE;
      cfg_r[4] <= '0; cfg_r[5] <= '0; cfg_r[6] <= '0; cfg_r[7] <= ONE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we && unused_idx < (kf2_pkg::CFG_IDX_W+1)'(NUM_CFG))
        cfg_r[cfg_index] <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r     <= in_data.req_type;
            meas_r    <= in_data.measurement;
            sat_r     <= 1'b0;
            skip_r    <= 1'b0;
            div_sel_r <= 1'b0;
            if (in_data.req_type == REQ_LOAD) begin
              x0_r  <= in_data.init_angle;
              x1_r  <= in_data.init_velocity;
              p00_r <= in_data.init_p00;
              p01_r <= in_data.init_p01;
              p10_r <= in_data.init_p10;
              p11_r <= in_data.init_p11;
            end
          end
        end
        ST_MAC: begin
          if (dst != 4'd0) begin
            if (clsat) sat_r <= 1'b1;
            if (req_r == REQ_UPDATE && step_r == 5'd3 && clw == '0) begin
              skip_r <= 1'b1;
              k0_r <= '0; k1_r <= '0;
            end
          end
          if (req_r == REQ_UPDATE && step_r == 5'd9) begin
            // hold originals for covariance update
            t2_r <= p00_r; t3_r <= p01_r;
          end
          case (dst)
            4'd1:  x0_r <= clw;
            4'd2:  x1_r <= clw;
            4'd3:  p00_r <= clw;
            4'd4:  p01_r <= clw;
            4'd5:  p10_r <= clw;
            4'd6:  p11_r <= clw;
            4'd7:  t0_r <= clw;
            4'd8:  t1_r <= clw;
            4'd9:  t2_r <= clw;
            4'd10: t3_r <= clw;
            4'd11: y_r <= clw;
            4'd12: s_r <= clw;
            default: ;
          endcase
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            if (!skip_r) begin
              if (div_sat) sat_r <= 1'b1;
              if (div_sel_r) k1_r <= div_q; else k0_r <= div_q;
            end
            div_sel_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== dv/tb_kalman_filter_2state_velocity_meas_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_kalman_filter_2state_velocity_meas_core: self-checking Kalman core bench
// Drives predict, update, load and no-op requests through identity, extreme
// and random settings of F, Q and R, models the fixed-point filter locally and compares each result.
// ============================================================================
module tb_kalman_filter_2state_velocity_meas_core;
  import kf2_pkg::*;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  kalman_filter_2state_velocity_meas_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // filter shadow: configuration and state
  longint mdl_f[8];
  longint x_ang, x_vel, p00, p01, p10, p11;
  bit clamp_hit;
  out_item_t est_q[$];
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint clampw(longint v);
    if (v > WMAX) begin
      clamp_hit = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      clamp_hit = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // product rounded half up at the fraction point
  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  // scaled quotient, nearest with ties away from zero
  function automatic longint qdiv(longint n, longint d);
    longint un, ud, q;
    un = (n < 0 ? -n : n) <<< 16;
    ud = d < 0 ? -d : d;
    q = (un + (ud >>> 1)) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic out_item_t estimate(in_item_t it);
    longint t00, t01, t10, t11, x0, x1, y, s, k0, k1, m01, m11, a, b, c, d;
    out_item_t r;
    bit skip;
    skip = 1'b0;
    clamp_hit = 1'b0;
    case (it.req_type)
      REQ_PREDICT: begin
        x0 = x_ang;
        x1 = x_vel;
        x_ang = clampw(qmul(mdl_f[CFG_F00], x0) + qmul(mdl_f[CFG_F01], x1));
        x_vel = clampw(qmul(mdl_f[CFG_F10], x0) + qmul(mdl_f[CFG_F11], x1));
        t00 = clampw(qmul(p00, mdl_f[CFG_F00]) + qmul(p01, mdl_f[CFG_F01]));
        t01 = clampw(qmul(p00, mdl_f[CFG_F10]) + qmul(p01, mdl_f[CFG_F11]));
        t10 = clampw(qmul(p10, mdl_f[CFG_F00]) + qmul(p11, mdl_f[CFG_F01]));
        t11 = clampw(qmul(p10, mdl_f[CFG_F10]) + qmul(p11, mdl_f[CFG_F11]));
        p00 = clampw(qmul(mdl_f[CFG_F00], t00) + qmul(mdl_f[CFG_F01], t10)
                     + mdl_f[CFG_Q00]);
        p01 = clampw(qmul(mdl_f[CFG_F00], t01) + qmul(mdl_f[CFG_F01], t11)
                     + mdl_f[CFG_QOD]);
        p10 = clampw(qmul(mdl_f[CFG_F10], t00) + qmul(mdl_f[CFG_F11], t10)
                     + mdl_f[CFG_QOD]);
        p11 = clampw(qmul(mdl_f[CFG_F10], t01) + qmul(mdl_f[CFG_F11], t11)
                     + mdl_f[CFG_Q11]);
      end
      REQ_UPDATE: begin
        y = clampw(longint'(it.measurement) - x_vel);
        s = clampw(p11 + mdl_f[CFG_R]);
        k0 = 0;
        k1 = 0;
        a = p00; b = p01; c = p10; d = p11;
        skip = (s == 0);
        if (!skip) begin
          k0 = clampw(qdiv(b, s));
          k1 = clampw(qdiv(d, s));
        end
        x_ang = clampw(x_ang + qmul(k0, y));
        x_vel = clampw(x_vel + qmul(k1, y));
        m01 = clampw(-k0);
        m11 = clampw(ONE - k1);
        p00 = clampw(a + qmul(m01, c));
        p01 = clampw(b + qmul(m01, d));
        p10 = clampw(qmul(m11, c));
        p11 = clampw(qmul(m11, d));
      end
      REQ_LOAD: begin
        x_ang = it.init_angle;
        x_vel = it.init_velocity;
        p00 = it.init_p00;
        p01 = it.init_p01;
        p10 = it.init_p10;
        p11 = it.init_p11;
      end
      default: ;
    endcase
    r.angle_est = x_ang[31:0];
    r.velocity_est = x_vel[31:0];
    r.gain_skipped = skip;
    r.saturated = (it.req_type == REQ_LOAD || it.req_type == REQ_NOP) ? 1'b0 : clamp_hit;
    return r;
  endfunction

  // compare each result transaction against the oldest estimate
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (est_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = est_q.pop_front();
        if (out_data.angle_est !== e.angle_est) begin
          $display("%0t: angle exp %h got %h", $time, e.angle_est, out_data.angle_est);
          errors++;
        end
        if (out_data.velocity_est !== e.velocity_est) begin
          $display("%0t: velocity exp %h got %h", $time, e.velocity_est,
                   out_data.velocity_est);
          errors++;
        end
        if (out_data.gain_skipped !== e.gain_skipped) begin
          $display("%0t: skip exp %b got %b", $time, e.gain_skipped, out_data.gain_skipped);
          errors++;
        end
        if (out_data.saturated !== e.saturated) begin
          $display("%0t: sat exp %b got %b", $time, e.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // random receiver stalls, with quiet stretches
  int stall_left;
  bit stall_on;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!out_ready || out_valid) begin
      out_ready <= 1'b1;
      if (out_ready && out_valid && stall_on) stall_left <= $urandom_range(0, 9);
    end
  end
  always begin
    stall_on = 1'b1;
    repeat (2000) @(posedge clk);
    stall_on = 1'b0;
    repeat (600) @(posedge clk);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 4)) << 16;
      3: return 32'($signed($urandom_range(0, 65536 * 4)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  // hold a request until accepted, after a random gap; valid drops only
  // when a gap follows, so back-to-back requests keep it high
  task automatic send_req(in_item_t it, bit gap = 1'b1);
    int idle;
    idle = gap ? $urandom_range(0, 9) : 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    est_q.push_back(estimate(it));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // write enable stays high across a burst; the caller drops it
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    mdl_f[idx] = longint'($signed(val));
    @(posedge clk);
  endtask

  function automatic in_item_t mk_item(logic [1:0] req);
    in_item_t it;
    it.req_type = req;
    it.measurement = rand_word();
    it.init_angle = rand_word();
    it.init_velocity = rand_word();
    it.init_p00 = rand_word();
    it.init_p01 = rand_word();
    it.init_p10 = rand_word();
    it.init_p11 = rand_word();
    return it;
  endfunction

  // directed: each request, extremes, zero s, most negative gain
  task automatic test_directed();
    in_item_t it;
    send_req(mk_item(REQ_PREDICT));
    send_req(mk_item(REQ_UPDATE));
    send_req(mk_item(REQ_NOP));
    it = mk_item(REQ_LOAD);
    it.init_angle = 32'h7fffffff; it.init_velocity = 32'h80000000;
    it.init_p00 = 32'h7fffffff; it.init_p01 = 32'h80000000;
    it.init_p10 = 32'h80000000; it.init_p11 = 32'h7fffffff;
    send_req(it);
    send_req(mk_item(REQ_PREDICT));
    it = mk_item(REQ_UPDATE);
    it.measurement = 32'h80000000;
    send_req(it);
    // s = P11 + R = 0 skips the gain
    it = mk_item(REQ_LOAD);
    it.init_p11 = -32'sd65536;
    send_req(it);
    send_req(mk_item(REQ_UPDATE));
    // tiny s drives gains to the rails, so -k0 clamps
    it = mk_item(REQ_LOAD);
    it.init_p11 = -32'sd65535; it.init_p01 = 32'h80000000;
    send_req(it);
    send_req(mk_item(REQ_UPDATE));
    it = mk_item(REQ_LOAD);
    it.init_p11 = -32'sd65535; it.init_p01 = 32'h7fffffff;
    send_req(it);
    it = mk_item(REQ_UPDATE);
    it.measurement = 32'h7fffffff;
    send_req(it);
    it = mk_item(REQ_LOAD);
    it = '0;
    it.req_type = REQ_LOAD;
    send_req(it);
    send_req(mk_item(REQ_NOP));
    wait_idle();
  endtask

  // a random mix of load, no-op, predict and update requests with random content
  task automatic test_random_run(int n);
    in_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) it = mk_item(REQ_LOAD);
      else if (r < 12) it = mk_item(REQ_NOP);
      else if (r < 56) it = mk_item(REQ_PREDICT);
      else it = mk_item(REQ_UPDATE);
      if (it.req_type == REQ_LOAD && $urandom_range(0, 1)) begin
        it.init_p00 = $urandom_range(0, 1 << 20);
        it.init_p11 = $urandom_range(0, 1 << 20);
        it.init_p01 = $urandom_range(0, 1 << 18);
        it.init_p10 = it.init_p01;
      end
      send_req(it, i % 200 < 150);
    end
    wait_idle();
  endtask

  // random configuration, with extremes and typical values
  task automatic test_config_sweep(int phase);
    logic [31:0] v;
    for (int k = 0; k < NUM_CFG; k++) begin
      case (phase % 4)
        0: v = (k == CFG_F00 || k == CFG_F11 || k == CFG_R) ? 32'h10000 : 32'h0;
        1: v = (k % 2) ? 32'h7fffffff : 32'h80000000;
        default: v = ($urandom_range(0, 2) == 0) ? rand_word()
                   : 32'($signed($urandom_range(0, 131072)) - 32768);
      endcase
      write_cfg(k[CFG_IDX_W-1:0], v);
    end
    if (phase % 4 > 1) write_cfg(CFG_F01, 32'h0000_0666);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    mdl_f[CFG_F00] = ONE; mdl_f[CFG_F01] = 0; mdl_f[CFG_F10] = 0; mdl_f[CFG_F11] = ONE;
    mdl_f[CFG_Q00] = 0; mdl_f[CFG_QOD] = 0; mdl_f[CFG_Q11] = 0; mdl_f[CFG_R] = ONE;
    x_ang = 0; x_vel = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int ph = 0; ph < 16; ph++) begin
      test_config_sweep(ph);
      test_random_run(100);
    end
    wait_idle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
